[rtl/sqb_pkg.sv]
// shared types and constants of the stack and queue byte buffer
package sqb_pkg;

   localparam int DEFAULT_DEPTH = 8;
   localparam int BYTE_W        = 8;
   localparam int CMD_W         = 3;
   localparam int STATUS_W      = 2;
   localparam int COUNT_OUT_W   = 4;
   localparam int RSP_DATA_W    = BYTE_W + 2 * COUNT_OUT_W;

   // request queue between front and back end, depth a power of two
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   // command codes as they arrive on the request channel
   localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DEQ   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DUMP  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

   // decoded operation carried to the back end
   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_DEQ   = 3'd2,
      OP_DUMP  = 3'd3,
      OP_CLEAR = 3'd4,
      OP_NOP   = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE  = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] data;
   } sqb_req_type;

endpackage

[rtl/sqb_front.sv]
// front end: takes requests, decodes the command and hands them to the queue
module sqb_front import sqb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]  req_tuser,
   output logic              fq_valid,
   output sqb_req_type       fq_req,
   input  logic              fq_ready
);

   logic        valid_ff, valid_in;
   sqb_req_type req_ff, req_in;
   op_type      op_dec;

   assign req_tready = !valid_ff || fq_ready;

   always_comb begin
      case (req_tuser)
         CMD_PUSH:  op_dec = OP_PUSH;
         CMD_POP:   op_dec = OP_POP;
         CMD_DEQ:   op_dec = OP_DEQ;
         CMD_DUMP:  op_dec = OP_DUMP;
         CMD_CLEAR: op_dec = OP_CLEAR;
         default:   op_dec = OP_NOP;
      endcase
   end

   always_comb begin
      req_in   = req_ff;
      valid_in = valid_ff && !fq_ready;
      if (req_tvalid && req_tready) begin
         req_in.op   = op_dec;
         req_in.data = req_tdata;
         valid_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      req_ff <= req_in;
   end

   assign fq_valid = valid_ff;
   assign fq_req   = req_ff;

endmodule

[rtl/sqb_queue.sv]
// short request queue decoupling front end and back end
module sqb_queue import sqb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_valid,
   input  sqb_req_type wr_req,
   output logic        wr_ready,
   output logic        rd_valid,
   output sqb_req_type rd_req,
   input  logic        rd_ready
);

   sqb_req_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_wr, do_rd;

   assign wr_ready = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_req   = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_req;
      end
   end

endmodule

[rtl/sqb_back.sv]
// back end: shift register store, operation sequencing and response register
module sqb_back import sqb_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  sqb_req_type           q_req,
   output logic                  q_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      BK_RUN  = 2'b01,
      BK_DUMP = 2'b10
   } back_state_type;

   logic [BYTE_W-1:0]      entries_ff [DEPTH];
   logic [BYTE_W-1:0]      entries_in [DEPTH];
   logic [BYTE_W-1:0]      shift_fwd  [DEPTH];
   logic [CNT_W-1:0]       held_ff, held_in, held_m1;
   logic [CNT_W-1:0]       dump_idx_ff, dump_idx_in;
   back_state_type         state_ff, state_in;
   logic                   out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]      out_byte_ff, out_byte_in;
   status_type             out_status_ff, out_status_in;
   logic                   out_last_ff, out_last_in;
   logic [COUNT_OUT_W-1:0] out_fill_ff, out_fill_in;
   logic [COUNT_OUT_W-1:0] out_free_ff, out_free_in;
   logic                   slot_free, emit;
   logic                   do_push, do_shift, do_rotate;
   logic [31:0]            cnt_wide, free_wide;

   // every entry moved one place towards the front
   for (genvar g = 0; g < DEPTH; g++) begin : g_shift
      if (g == DEPTH - 1) begin : g_end
         assign shift_fwd[g] = entries_ff[g];
      end else begin : g_mid
         assign shift_fwd[g] = entries_ff[g + 1];
      end
   end

   assign held_m1   = held_ff - CNT_W'(1);
   assign slot_free = !out_valid_ff || rsp_tready;

   always_comb begin
      held_in       = held_ff;
      dump_idx_in   = dump_idx_ff;
      state_in      = state_ff;
      q_ready       = 1'b0;
      emit          = 1'b0;
      do_push       = 1'b0;
      do_shift      = 1'b0;
      do_rotate     = 1'b0;
      out_byte_in   = out_byte_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      case (state_ff)
         BK_RUN: begin
            if (q_valid && slot_free) begin
               q_ready       = 1'b1;
               emit          = 1'b1;
               out_byte_in   = '0;
               out_status_in = STS_DONE;
               out_last_in   = 1'b1;
               case (q_req.op)
                  OP_PUSH: begin
                     if (held_ff < FULL_CNT) begin
                        do_push = 1'b1;
                        held_in = held_ff + CNT_W'(1);
                     end else begin
                        out_status_in = STS_FULL;
                     end
                  end
                  OP_POP: begin
                     if (held_ff == '0) begin
                        out_status_in = STS_EMPTY;
                     end else begin
                        out_byte_in = entries_ff[held_m1[IDX_W-1:0]];
                        held_in     = held_m1;
                     end
                  end
                  OP_DEQ: begin
                     if (held_ff == '0) begin
                        out_status_in = STS_EMPTY;
                     end else begin
                        out_byte_in = entries_ff[0];
                        do_shift    = 1'b1;
                        held_in     = held_m1;
                     end
                  end
                  OP_DUMP: begin
                     if (held_ff == '0) begin
                        out_status_in = STS_EMPTY;
                     end else begin
                        out_byte_in = entries_ff[0];
                        do_rotate   = 1'b1;
                        if (held_ff != CNT_W'(1)) begin
                           out_last_in = 1'b0;
                           dump_idx_in = CNT_W'(1);
                           state_in    = BK_DUMP;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     held_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_DUMP: begin
            if (slot_free) begin
               emit          = 1'b1;
               out_byte_in   = entries_ff[0];
               out_status_in = STS_DONE;
               do_rotate     = 1'b1;
               if (dump_idx_ff + CNT_W'(1) == held_ff) begin
                  out_last_in = 1'b1;
                  state_in    = BK_RUN;
               end else begin
                  out_last_in = 1'b0;
                  dump_idx_in = dump_idx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   // store update: append, shift forward, or rotate front entry to the back
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
         if (do_push && IDX_W'(i) == held_ff[IDX_W-1:0]) begin
            entries_in[i] = q_req.data;
         end else if (do_shift) begin
            entries_in[i] = shift_fwd[i];
         end else if (do_rotate) begin
            entries_in[i] = (IDX_W'(i) == held_m1[IDX_W-1:0]) ? entries_ff[0] : shift_fwd[i];
         end
      end
   end

   always_comb begin
      cnt_wide     = 32'(held_in);
      free_wide    = 32'(DEPTH) - cnt_wide;
      out_fill_in  = emit ? cnt_wide[COUNT_OUT_W-1:0] : out_fill_ff;
      out_free_in  = emit ? free_wide[COUNT_OUT_W-1:0] : out_free_ff;
      out_valid_in = emit || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         held_ff      <= '0;
         dump_idx_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         dump_idx_ff  <= dump_idx_in;
         out_valid_ff <= out_valid_in;
      end
      entries_ff    <= entries_in;
      out_byte_ff   <= out_byte_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
      out_fill_ff   <= out_fill_in;
      out_free_ff   <= out_free_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_free_ff, out_fill_ff, out_byte_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[rtl/stack_queue_buffer_unit.sv]
// top level of the stack and queue byte buffer
//
// a byte buffer of DEPTH entries usable as a stack and a queue at once: push appends at the
// back, pop takes the back entry, dequeue takes the front entry and moves the rest forward,
// dump streams every held entry front first with tlast on the final one, clear empties it.
// every response carries the fill count and free space after the request (both four bits
// wide, so they wrap for DEPTH above 15). a front end registers and decodes each request and
// drops it into a two-entry queue; the back end executes from the queue into a response
// register. push, pop, dequeue, clear and unused commands each give one response, so with a
// ready response side the unit sustains one request per cycle; a dump of n held entries
// holds the back end until it has given n responses (one when empty), one per cycle while
// the response side is ready, and meanwhile the front end and queue keep taking up to three
// requests. entries live in a shift register, so dequeue and dump rotation move all at once.
module stack_queue_buffer_unit import sqb_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH   // 1 to 64 entries
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // push_byte[7:0]
   input  logic [CMD_W-1:0]      req_tuser,   // cmd[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_byte[7:0], fill_count[11:8], free_space[15:12]
   output logic [STATUS_W-1:0]   rsp_tuser,   // status[1:0]
   output logic                  rsp_tlast    // last response of a request
);

   // decoded request from front end into the queue
   logic        fq_valid, fq_ready;
   sqb_req_type fq_req;

   // queue head towards the back end
   logic        bq_valid, bq_ready;
   sqb_req_type bq_req;

   sqb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fq_valid   (fq_valid),
      .fq_req     (fq_req),
      .fq_ready   (fq_ready)
   );

   sqb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_req   (fq_req),
      .wr_ready (fq_ready),
      .rd_valid (bq_valid),
      .rd_req   (bq_req),
      .rd_ready (bq_ready)
   );

   sqb_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (bq_valid),
      .q_req      (bq_req),
      .q_ready    (bq_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // fill and free always add up to the depth, modulo the count width
   a_fill_free_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         COUNT_OUT_W'(rsp_tdata[11:8] + rsp_tdata[15:12]) == COUNT_OUT_W'(DEPTH))
      else $error("fill and free space do not add up to the depth");

   // a rejected push only happens on a full buffer
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STS_FULL) |->
         (rsp_tdata[11:8] == COUNT_OUT_W'(DEPTH) && rsp_tdata[7:0] == '0 && rsp_tlast))
      else $error("full status with a buffer that is not full");

   // an empty response is a single closing response with nothing held
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STS_EMPTY) |->
         (rsp_tdata[11:8] == '0 && rsp_tdata[7:0] == '0 && rsp_tlast))
      else $error("empty status with entries held or more responses to follow");

endmodule

[dv/tb_stack_queue_buffer_unit.sv]
// self-checking testbench for the stack and queue byte buffer unit
`timescale 1ns / 100ps

module tb_stack_queue_buffer_unit;
   import sqb_pkg::*;

   localparam int DEPTH        = DEFAULT_DEPTH;
   localparam int RANDOM_COUNT = 310;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_WAIT  = 24;
   localparam int IDLE_PERCENT = 14;
   localparam int REPORT_MAX   = 10;

   // codes 5 to 7 are not decoded by the unit and must come back as a plain done
   localparam logic [CMD_W-1:0] CMD_FIRST_SPARE = 3'd5;
   localparam logic [CMD_W-1:0] CMD_LAST_SPARE  = 3'd7;

   typedef struct {
      logic [BYTE_W-1:0]      data;
      status_type             status;
      logic [COUNT_OUT_W-1:0] fill;
      logic [COUNT_OUT_W-1:0] room;
      logic                   tail;
   } buffer_result_type;

   // mirror of the buffer contents plus the results still owed by the unit
   class buffer_scoreboard;
      logic [BYTE_W-1:0] slots [DEPTH];
      int                held;
      buffer_result_type owed [$];
      int                mismatches;

      function new();
         held       = 0;
         mismatches = 0;
      endfunction

      function int outstanding();
         return owed.size();
      endfunction

      function void owe(logic [BYTE_W-1:0] data, status_type status, logic tail);
         buffer_result_type r;
         r.data   = data;
         r.status = status;
         r.fill   = COUNT_OUT_W'(held);
         r.room   = COUNT_OUT_W'(DEPTH - held);
         r.tail   = tail;
         owed.push_back(r);
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data);
         int                i;
         logic [BYTE_W-1:0] taken;
         case (cmd)
            CMD_PUSH: begin
               if (held < DEPTH) begin
                  slots[held] = data;
                  held++;
                  owe('0, STS_DONE, 1'b1);
               end else begin
                  owe('0, STS_FULL, 1'b1);
               end
            end
            CMD_POP: begin
               if (held == 0) begin
                  owe('0, STS_EMPTY, 1'b1);
               end else begin
                  held--;
                  owe(slots[held], STS_DONE, 1'b1);
               end
            end
            CMD_DEQ: begin
               if (held == 0) begin
                  owe('0, STS_EMPTY, 1'b1);
               end else begin
                  taken = slots[0];
                  for (i = 0; i + 1 < held; i++) slots[i] = slots[i + 1];
                  held--;
                  owe(taken, STS_DONE, 1'b1);
               end
            end
            CMD_DUMP: begin
               if (held == 0) begin
                  owe('0, STS_EMPTY, 1'b1);
               end else begin
                  for (i = 0; i < held; i++) owe(slots[i], STS_DONE, i + 1 == held);
               end
            end
            CMD_CLEAR: begin
               held = 0;
               owe('0, STS_DONE, 1'b1);
            end
            default: begin
               owe('0, STS_DONE, 1'b1);
            end
         endcase
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] tdata, logic [STATUS_W-1:0] tuser,
                                   logic tlast);
         buffer_result_type want;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: unexpected response data=%h status=%0d last=%0b",
                        $time, tdata, tuser, tlast);
            return;
         end
         want = owed.pop_front();
         if (tdata[7:0] !== want.data || tuser !== want.status ||
             tdata[11:8] !== want.fill || tdata[15:12] !== want.room || tlast !== want.tail) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("%0t: mismatch exp byte=%h st=%0d fill=%0d free=%0d last=%0b",
                        $time, want.data, want.status, want.fill, want.room, want.tail);
               $display("   got byte=%h st=%0d fill=%0d free=%0d last=%0b",
                        tdata[7:0], tuser, tdata[11:8], tdata[15:12], tlast);
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata;   // push_byte[7:0]
   logic [CMD_W-1:0]      req_tuser;   // cmd[2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // out_byte[7:0], fill_count[11:8], free_space[15:12]
   logic [STATUS_W-1:0]   rsp_tuser;   // status[1:0]
   logic                  rsp_tlast;

   buffer_scoreboard book;
   bit               quiet;            // suppresses idling on both sides
   int               cycles = 0;

   stack_queue_buffer_unit #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // response side stalls at random unless quiet
   always @(negedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // both handshakes are observed on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) book.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) book.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // one request, entered at a falling edge and left at the falling edge after acceptance
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data);
      if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         req_tdata  <= BYTE_W'($urandom);
         req_tuser  <= CMD_W'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // holds the request side off until every owed result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (book.outstanding() != 0) @(negedge clock);
   endtask

   function automatic logic [CMD_W-1:0] pick_cmd(bit filling);
      int r;
      r = $urandom_range(99);
      if (filling) begin
         if (r < 55) return CMD_PUSH;
         if (r < 65) return CMD_POP;
         if (r < 75) return CMD_DEQ;
         if (r < 90) return CMD_DUMP;
      end else begin
         if (r < 25) return CMD_PUSH;
         if (r < 48) return CMD_POP;
         if (r < 71) return CMD_DEQ;
         if (r < 90) return CMD_DUMP;
      end
      if (r < 96) return CMD_CLEAR;
      return CMD_LAST_SPARE - CMD_CLEAR < 1 ? CMD_CLEAR :
             CMD_W'($urandom_range(CMD_LAST_SPARE, CMD_FIRST_SPARE));
   endfunction

   initial begin
      int  n;
      bit  filling;
      book       = new();
      quiet      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_PUSH;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // removals and dump on an empty buffer
      send_request(CMD_POP, 8'h5a);
      send_request(CMD_DEQ, 8'ha5);
      send_request(CMD_DUMP, 8'hff);
      // fill to the brim with the byte extremes among the values
      send_request(CMD_PUSH, 8'h00);
      send_request(CMD_PUSH, 8'hff);
      for (n = 2; n < DEPTH; n++) send_request(CMD_PUSH, BYTE_W'($urandom));
      send_request(CMD_PUSH, 8'h3c);      // rejected, buffer full
      send_request(CMD_DUMP, 8'h00);      // full-length dump
      send_request(CMD_POP, 8'h00);
      send_request(CMD_DEQ, 8'h00);
      send_request(CMD_DUMP, 8'h00);
      send_request(CMD_FIRST_SPARE, 8'hff);
      send_request(CMD_W'(6), 8'h81);
      send_request(CMD_LAST_SPARE, 8'h7e);
      send_request(CMD_CLEAR, 8'hc3);
      send_request(CMD_DUMP, 8'h00);      // empty again after clear
      send_request(CMD_PUSH, 8'haa);
      send_request(CMD_DEQ, 8'h00);       // single entry, nothing to shift
      wait_drained();

      filling = 1'b1;
      for (n = 0; n < RANDOM_COUNT; n++) begin
         if (n % 30 == 0) filling = 1'($urandom_range(1));
         quiet = (n >= 120 && n < 200);
         if (n == 100 || n == 240) wait_drained();
         send_request(pick_cmd(filling), BYTE_W'($urandom));
      end

      quiet = 1'b0;
      req_tvalid <= 1'b0;
      while (book.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
      if (book.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[files.f]
rtl/sqb_pkg.sv
rtl/sqb_front.sv
rtl/sqb_queue.sv
rtl/sqb_back.sv
rtl/stack_queue_buffer_unit.sv
dv/tb_stack_queue_buffer_unit.sv
